// ----- rtl/core/fdss_pkg.sv -----
// Shared types, constants and segment table for the four-digit display formatter.
package fdss_pkg;

	// Largest value the four digits can show
	localparam int unsigned DisplayMax = 9999;
	// Width of a saturated value
	localparam int unsigned ValW = 14;
	localparam int unsigned NumDigits = 4;
	localparam int unsigned IdxW = 2;
	localparam logic [IdxW-1:0] LastIdx = IdxW'(NumDigits - 1);

	// Reciprocal constants for division by 1000, 100 and 10
	localparam logic [27:0] RecipThousand = 28'd8389; // 2^-23 scale
	localparam int unsigned ShThousand = 23;
	localparam logic [15:0] RecipHundred = 16'd41; // 2^-12 scale
	localparam int unsigned ShHundred = 12;
	localparam logic [14:0] RecipTen = 15'd205; // 2^-11 scale
	localparam int unsigned ShTen = 11;

	localparam logic [7:0] BlankPattern = 8'hFF;
	localparam logic [7:0] LeftSelect = 8'h08;

	typedef logic [3:0] bcd_t;

	// Four decimal digits, d0 most significant
	typedef struct packed {
		bcd_t d0;
		bcd_t d1;
		bcd_t d2;
		bcd_t d3;
	} digits_t;

	// Common-anode, active-low segment table
	function automatic logic [7:0] seg_lookup(input bcd_t d);
		logic [7:0] p;
		case (d)
			4'd0: p = 8'hC0;
			4'd1: p = 8'hF9;
			4'd2: p = 8'hA4;
			4'd3: p = 8'hB0;
			4'd4: p = 8'h99;
			4'd5: p = 8'h92;
			4'd6: p = 8'h82;
			4'd7: p = 8'hF8;
			4'd8: p = 8'h80;
			4'd9: p = 8'h90;
			default: p = BlankPattern;
		endcase
		return p;
	endfunction

endpackage

// ----- rtl/core/fdss_digits.sv -----
// Saturation and binary-to-decimal split, four short pipeline stages.
module fdss_digits import fdss_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [31:0]     value,
	output logic            dig_valid,
	input  logic            dig_ready,
	output digits_t         digits
);

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic [ValW-1:0] v_s1, v_s2;
	bcd_t            d0_s2, d0_s3, d1_s3;
	logic [9:0]      r1_s3;
	digits_t         dig_s4;

	logic [27:0] prod_k;
	logic [13:0] r1_full;
	logic [9:0]  r1;
	logic [15:0] prod_h;
	logic [9:0]  r2_full;
	logic [6:0]  r2;
	logic [14:0] prod_t;
	bcd_t        d2;
	logic [6:0]  d3_full;

	// Elastic stall chain: a stage loads when it is empty or drains
	assign rdy4     = !valid_s4 || dig_ready;
	assign rdy3     = !valid_s3 || rdy4;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	// Stage 2: thousands digit by reciprocal multiply
	assign prod_k = 28'(v_s1) * RecipThousand;

	// Stage 3: remainder below 1000, then hundreds digit
	assign r1_full = v_s2 - 14'(d0_s2) * 14'd1000;
	assign r1      = r1_full[9:0];
	assign prod_h  = 16'(r1) * RecipHundred;

	// Stage 4: remainder below 100, tens and ones
	assign r2_full = r1_s3 - 10'(d1_s3) * 10'd100;
	assign r2      = r2_full[6:0];
	assign prod_t  = 15'(r2) * RecipTen;
	assign d2      = prod_t[ShTen +: 4];
	assign d3_full = r2 - 7'(d2) * 7'd10;

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			v_s1 <= (value > 32'(DisplayMax)) ? ValW'(DisplayMax) : value[ValW-1:0];
		end
		if (rdy2 && valid_s1) begin
			v_s2  <= v_s1;
			d0_s2 <= prod_k[ShThousand +: 4];
		end
		if (rdy3 && valid_s2) begin
			d0_s3 <= d0_s2;
			d1_s3 <= prod_h[ShHundred +: 4];
			r1_s3 <= r1;
		end
		if (rdy4 && valid_s3) begin
			dig_s4.d0 <= d0_s3;
			dig_s4.d1 <= d1_s3;
			dig_s4.d2 <= d2;
			dig_s4.d3 <= d3_full[3:0];
		end
	end

	assign dig_valid = valid_s4;
	assign digits    = dig_s4;

endmodule

// ----- rtl/core/fdss_serializer.sv -----
// Segment mapping with leading-zero blanking and one-digit-per-transfer output.
module fdss_serializer import fdss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        dig_valid,
	output logic        dig_ready,
	input  digits_t     digits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  segment_pattern,
	output logic [7:0]  digit_select,
	output logic        last_digit
);

	logic                 busy_q;
	logic [IdxW-1:0]      idx_q;
	logic [NumDigits-1:0][7:0] pat_q;

	logic blank0, blank1, blank2;
	logic xfer, last_xfer, load;

	// Leading zeros blank; the rightmost digit always shows
	assign blank0 = (digits.d0 == 4'd0);
	assign blank1 = blank0 && (digits.d1 == 4'd0);
	assign blank2 = blank1 && (digits.d2 == 4'd0);

	assign xfer      = busy_q && out_ready;
	assign last_xfer = xfer && (idx_q == LastIdx);
	assign dig_ready = !busy_q || last_xfer;
	assign load      = dig_valid && dig_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (xfer) begin
				idx_q <= idx_q + IdxW'(1);
				if (last_xfer) busy_q <= 1'b0;
			end
		end
	end

	// Pattern bytes, leftmost in entry 0
	always_ff @(posedge clk) begin
		if (load) begin
			pat_q[0] <= blank0 ? BlankPattern : seg_lookup(digits.d0);
			pat_q[1] <= blank1 ? BlankPattern : seg_lookup(digits.d1);
			pat_q[2] <= blank2 ? BlankPattern : seg_lookup(digits.d2);
			pat_q[3] <= seg_lookup(digits.d3);
		end
	end

	assign out_valid       = busy_q;
	assign segment_pattern = pat_q[idx_q];
	assign digit_select    = LeftSelect >> idx_q;
	assign last_digit      = (idx_q == LastIdx);

endmodule

// ----- rtl/core/four_digit_seven_segment_formatter.sv -----
// Top level of the four-digit seven-segment formatter.
//
// Input channel (in_valid/in_ready, value): one unsigned 32-bit number per
// transfer. Values above 9999 are shown as 9999.
// Output channel (out_valid/out_ready): four transfers per number, leftmost
// digit first, each with an active-low segment byte (0xFF when a leading
// zero is blanked), a one-hot digit_select (0x08 down to 0x01) and
// last_digit set on the rightmost digit. Zero shows as a single "0".
// The first digit of a number is offered once the number has passed the
// four split stages and been loaded into the serializer, when the output side is free.
// Throughput: one digit per cycle while out_ready stays high; the output
// serializer sets the pace. A four-stage split pipeline (saturate,
// thousands, hundreds, tens/ones) feeds it and keeps accepting numbers
// until all its stages are full.
// Reset clears all valid flags; no output is offered until a new number.
// When the receiver stalls, the current digit holds steady and the pipeline
// backs up stage by stage before in_ready drops.
module four_digit_seven_segment_formatter import fdss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  segment_pattern,
	output logic [7:0]  digit_select,
	output logic        last_digit
);

	logic    dig_valid;
	logic    dig_ready;
	digits_t digits;

	fdss_digits u_digits (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.dig_valid (dig_valid),
		.dig_ready (dig_ready),
		.digits    (digits)
	);

	fdss_serializer u_serializer (
		.clk             (clk),
		.arst_n          (arst_n),
		.dig_valid       (dig_valid),
		.dig_ready       (dig_ready),
		.digits          (digits),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.segment_pattern (segment_pattern),
		.digit_select    (digit_select),
		.last_digit      (last_digit)
	);

endmodule
